### rtl/core/twdsw_pkg.sv
`timescale 1ns / 1ps

package twdsw_pkg;

    // Data slots after the command byte
    localparam int DIGITS        = 6;
    localparam int STORE_LEN     = DIGITS + 1;
    localparam int BITS_PER_BYTE = 8;

    localparam logic [2:0] MAX_SLOT  = 3'(DIGITS);
    localparam logic [7:0] MAX_COUNT = 8'(DIGITS);
    localparam logic [2:0] LAST_BIT  = 3'(BITS_PER_BYTE - 1);

    // Operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BUSY     = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    // Line sequencer phases
    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_START     = 4'd1;
    localparam logic [3:0] PH_CLK_FALL  = 4'd2;
    localparam logic [3:0] PH_DATA      = 4'd3;
    localparam logic [3:0] PH_CLK_RISE  = 4'd4;
    localparam logic [3:0] PH_HOLD      = 4'd5;
    localparam logic [3:0] PH_ACK_SETUP = 4'd6;
    localparam logic [3:0] PH_ACK_RISE  = 4'd7;
    localparam logic [3:0] PH_ACK_CHECK = 4'd8;
    localparam logic [3:0] PH_ACK_DONE  = 4'd9;
    localparam logic [3:0] PH_STOP      = 4'd10;
    localparam logic [3:0] PH_END       = 4'd11;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] slot;
        logic [7:0] byte_value;
        logic [7:0] data_count;
        logic       dio_sample;
    } item_t;

    typedef struct packed {
        logic       clk_level;
        logic       dio_level;
        logic       dio_released;
        logic       busy_res;
        logic [1:0] status;
    } result_t;

endpackage

### rtl/core/twdsw_item_if.sv
`timescale 1ns / 1ps

interface twdsw_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [2:0] slot;
    logic [7:0] byte_value;
    logic [7:0] data_count;
    logic       dio_sample;

    modport source (output valid, output operation, output slot, output byte_value,
                    output data_count, output dio_sample, input ready);
    modport sink   (input valid, input operation, input slot, input byte_value,
                    input data_count, input dio_sample, output ready);
endinterface

### rtl/core/twdsw_result_if.sv
`timescale 1ns / 1ps

interface twdsw_result_if;
    logic       valid;
    logic       ready;
    logic       clk_level;
    logic       dio_level;
    logic       dio_released;
    logic       busy_res;
    logic [1:0] status;

    modport source (output valid, output clk_level, output dio_level, output dio_released,
                    output busy_res, output status, input ready);
    modport sink   (input valid, input clk_level, input dio_level, input dio_released,
                    input busy_res, input status, output ready);
endinterface

### rtl/core/twdsw_engine.sv
`timescale 1ns / 1ps

module twdsw_engine
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  twdsw_pkg::item_t   item_word,
    output twdsw_pkg::result_t result_word
);

    logic [3:0] phase_reg,    phase_next;
    logic       running_reg,  running_next;
    logic [2:0] bit_pos_reg,  bit_pos_next;
    logic [2:0] byte_pos_reg, byte_pos_next;
    logic [2:0] total_reg,    total_next;
    logic       clk_reg,      clk_next;
    logic       dio_reg,      dio_next;
    logic       release_reg,  release_next;
    logic [1:0] status;
    logic       store_wr;
    logic [7:0] cur_byte;

    logic [7:0] store_reg [twdsw_pkg::STORE_LEN];

    // Slot past the last data byte reads as zero
    assign cur_byte = (byte_pos_reg < 3'(twdsw_pkg::STORE_LEN)) ? store_reg[byte_pos_reg]
                                                                 : 8'd0;

    always_comb
    begin
        phase_next    = phase_reg;
        running_next  = running_reg;
        bit_pos_next  = bit_pos_reg;
        byte_pos_next = byte_pos_reg;
        total_next    = total_reg;
        clk_next      = clk_reg;
        dio_next      = dio_reg;
        release_next  = release_reg;
        status        = twdsw_pkg::ST_OK;
        store_wr      = 1'b0;

        case (item_word.operation)
            twdsw_pkg::OP_TICK:
            begin
                if (running_reg)
                begin
                    case (phase_reg)
                        twdsw_pkg::PH_IDLE:
                        begin
                            clk_next     = 1'b1;
                            dio_next     = 1'b1;
                            release_next = 1'b0;
                            phase_next   = twdsw_pkg::PH_START;
                        end
                        twdsw_pkg::PH_START:
                        begin
                            dio_next   = 1'b0;
                            phase_next = twdsw_pkg::PH_CLK_FALL;
                        end
                        twdsw_pkg::PH_CLK_FALL:
                        begin
                            clk_next   = 1'b0;
                            phase_next = twdsw_pkg::PH_DATA;
                        end
                        twdsw_pkg::PH_DATA:
                        begin
                            dio_next   = cur_byte[bit_pos_reg];
                            phase_next = twdsw_pkg::PH_CLK_RISE;
                        end
                        twdsw_pkg::PH_CLK_RISE:
                        begin
                            clk_next   = 1'b1;
                            phase_next = twdsw_pkg::PH_HOLD;
                        end
                        twdsw_pkg::PH_HOLD:
                        begin
                            if (bit_pos_reg == twdsw_pkg::LAST_BIT)
                            begin
                                bit_pos_next = 3'd0;
                                phase_next   = twdsw_pkg::PH_ACK_SETUP;
                            end
                            else
                            begin
                                bit_pos_next = bit_pos_reg + 3'd1;
                                phase_next   = twdsw_pkg::PH_CLK_FALL;
                            end
                        end
                        twdsw_pkg::PH_ACK_SETUP:
                        begin
                            clk_next     = 1'b0;
                            dio_next     = 1'b1;
                            release_next = 1'b1;
                            phase_next   = twdsw_pkg::PH_ACK_RISE;
                        end
                        twdsw_pkg::PH_ACK_RISE:
                        begin
                            clk_next   = 1'b1;
                            phase_next = twdsw_pkg::PH_ACK_CHECK;
                        end
                        twdsw_pkg::PH_ACK_CHECK:
                        begin
                            // hold until the partner pulls data low
                            if (!item_word.dio_sample)
                                phase_next = twdsw_pkg::PH_ACK_DONE;
                        end
                        twdsw_pkg::PH_ACK_DONE:
                        begin
                            clk_next     = 1'b1;
                            dio_next     = 1'b1;
                            release_next = 1'b0;
                            if (byte_pos_reg >= total_reg)
                                phase_next = twdsw_pkg::PH_STOP;
                            else
                            begin
                                byte_pos_next = byte_pos_reg + 3'd1;
                                phase_next    = twdsw_pkg::PH_CLK_FALL;
                            end
                        end
                        twdsw_pkg::PH_STOP:
                        begin
                            dio_next   = 1'b0;
                            phase_next = twdsw_pkg::PH_END;
                        end
                        default:
                        begin
                            clk_next     = 1'b1;
                            dio_next     = 1'b1;
                            release_next = 1'b0;
                            running_next = 1'b0;
                            phase_next   = twdsw_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
            twdsw_pkg::OP_LOAD:
            begin
                if (running_reg)
                    status = twdsw_pkg::ST_BUSY;
                else if (item_word.slot > twdsw_pkg::MAX_SLOT)
                    status = twdsw_pkg::ST_TOO_LONG;
                else
                    store_wr = 1'b1;
            end
            twdsw_pkg::OP_START:
            begin
                if (running_reg)
                    status = twdsw_pkg::ST_BUSY;
                else if (item_word.data_count > twdsw_pkg::MAX_COUNT)
                    status = twdsw_pkg::ST_TOO_LONG;
                else
                begin
                    total_next    = item_word.data_count[2:0];
                    byte_pos_next = 3'd0;
                    bit_pos_next  = 3'd0;
                    phase_next    = twdsw_pkg::PH_IDLE;
                    running_next  = 1'b1;
                end
            end
            default:
            begin
                status = twdsw_pkg::ST_OK;
            end
        endcase
    end

    assign result_word.clk_level    = clk_next;
    assign result_word.dio_level    = dio_next;
    assign result_word.dio_released = release_next;
    assign result_word.busy_res     = running_next;
    assign result_word.status       = status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= twdsw_pkg::PH_IDLE;
            running_reg  <= 1'b0;
            bit_pos_reg  <= 3'd0;
            byte_pos_reg <= 3'd0;
            total_reg    <= 3'd0;
            clk_reg      <= 1'b1;
            dio_reg      <= 1'b1;
            release_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            running_reg  <= running_next;
            bit_pos_reg  <= bit_pos_next;
            byte_pos_reg <= byte_pos_next;
            total_reg    <= total_next;
            clk_reg      <= clk_next;
            dio_reg      <= dio_next;
            release_reg  <= release_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && store_wr)
            store_reg[item_word.slot] <= item_word.byte_value;
    end

endmodule

### rtl/core/twdsw_out_stage.sv
`timescale 1ns / 1ps

module twdsw_out_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  twdsw_pkg::result_t load_word,
    input  logic               take,
    output logic               room,
    output logic               valid,
    output twdsw_pkg::result_t word
);

    logic               valid_reg, valid_next;
    twdsw_pkg::result_t word_reg;

    // Free when empty or when the held word leaves this cycle
    assign room       = !valid_reg || take;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            word_reg <= load_word;
    end

    assign valid = valid_reg;
    assign word  = word_reg;

endmodule

### rtl/core/two_wire_display_serial_writer.sv
`timescale 1ns / 1ps
// Channel   Role    Fields
// item      sink    operation, slot, byte_value, data_count, dio_sample
// result    source  clk_level, dio_level, dio_released, busy_res, status
//
// One word in per cycle when not stalled; its result is registered and shows the next cycle.
// The line sequencer state updates in the same cycle the word is taken.
// Reset clears the sequencer to idle with both lines high; the byte buffer is not cleared.
// A stalled result holds in the output register and holds off the next word.

module two_wire_display_serial_writer
(
    input logic            clk,
    input logic            rst_n,
    twdsw_item_if.sink     item,
    twdsw_result_if.source result
);

    twdsw_pkg::item_t   item_word;
    twdsw_pkg::result_t next_word;
    twdsw_pkg::result_t out_word;
    logic               accept;
    logic               room;
    logic               out_valid;

    assign item_word.operation  = item.operation;
    assign item_word.slot       = item.slot;
    assign item_word.byte_value = item.byte_value;
    assign item_word.data_count = item.data_count;
    assign item_word.dio_sample = item.dio_sample;

    assign item.ready = room;
    assign accept     = item.valid && room;

    twdsw_engine u_engine
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item_word   (item_word),
        .result_word (next_word)
    );

    twdsw_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_word (next_word),
        .take      (result.ready),
        .room      (room),
        .valid     (out_valid),
        .word      (out_word)
    );

    assign result.valid        = out_valid;
    assign result.clk_level    = out_word.clk_level;
    assign result.dio_level    = out_word.dio_level;
    assign result.dio_released = out_word.dio_released;
    assign result.busy_res     = out_word.busy_res;
    assign result.status       = out_word.status;

endmodule

### rtl/core/twdsw_checker.sv
`timescale 1ns / 1ps

module twdsw_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_dio_level,
    input logic       out_dio_released,
    input logic       out_busy_res,
    input logic [1:0] out_status
);

    // Stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status)
                                    && $stable(out_busy_res))
    else $error("result word changed under stall");

    // Every taken word yields a result word next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

    // Busy rejection only while a transfer runs
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status == twdsw_pkg::ST_BUSY |-> out_busy_res)
    else $error("busy status without running transfer");

    // Released data line reads high and only during a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_dio_released |-> out_dio_level && out_busy_res)
    else $error("data line released outside acknowledge");

endmodule

bind two_wire_display_serial_writer twdsw_checker u_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (item.valid),
    .in_ready         (item.ready),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .out_dio_level    (result.dio_level),
    .out_dio_released (result.dio_released),
    .out_busy_res     (result.busy_res),
    .out_status       (result.status)
);
